// File: design/afb_pkg.sv
package afb_pkg;

	// Fixed bytes of a local AT-command API frame.
	localparam logic [7:0] START_DELIM  = 8'h7E;
	localparam logic [7:0] LEN_HIGH     = 8'h00;
	localparam logic [7:0] API_AT_CMD   = 8'h08;
	localparam logic [7:0] FRAME_ID_RST = 8'hA1;
	localparam logic [7:0] CSUM_INIT    = 8'hFF;
	localparam logic [7:0] LEN_BASE     = 8'd4;

	// Input command codes.
	localparam logic CMD_BEGIN  = 1'b0;
	localparam logic CMD_OPTION = 1'b1;

	localparam int MAX_BYTES = 8;

	// All bytes caused by one request, first byte in bytes[0].
	typedef struct packed {
		logic [3:0]                cnt;
		logic                      has_end;
		logic [MAX_BYTES-1:0][7:0] bytes;
	} afb_rec_t;

endpackage

// File: design/afb_encode.sv
module afb_encode import afb_pkg::*; #(
	parameter int MAX_OPTIONS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           command,
	input  logic [7:0]     at_char0,
	input  logic [7:0]     at_char1,
	input  logic [6:0]     option_count,
	input  logic [7:0]     option_byte,
	output logic           rec_valid,
	output afb_rec_t       rec,
	input  logic           rec_take
);

	logic [7:0] frame_counter_q;
	logic [7:0] checksum_q;
	logic [6:0] options_left_q;
	logic       rec_valid_s1;
	afb_rec_t   rec_s1;

	logic       in_acc;
	logic [6:0] count_sat;
	logic [7:0] id_inc;
	logic [7:0] id_next;
	logic [7:0] csum_begin;
	logic [7:0] csum_opt;
	afb_rec_t   rec_d;
	logic [7:0] ctr_d;
	logic [7:0] csum_d;
	logic [6:0] left_d;

	assign in_ready = !rec_valid_s1 || rec_take;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		if (int'(option_count) > MAX_OPTIONS) begin
			count_sat = 7'(MAX_OPTIONS);
		end else begin
			count_sat = option_count;
		end
	end

	// The frame id never takes zero: 0xFF steps to 0x01.
	assign id_inc     = frame_counter_q + 8'd1;
	assign id_next    = (id_inc == 8'd0) ? 8'd1 : id_inc;
	assign csum_begin = CSUM_INIT - API_AT_CMD - id_next - at_char0 - at_char1;
	assign csum_opt   = checksum_q - option_byte;

	always_comb begin
		rec_d   = '0;
		ctr_d   = frame_counter_q;
		csum_d  = checksum_q;
		left_d  = options_left_q;
		unique case (command)
			CMD_BEGIN: begin
				rec_d.bytes[0] = START_DELIM;
				rec_d.bytes[1] = LEN_HIGH;
				rec_d.bytes[2] = LEN_BASE + 8'(count_sat);
				rec_d.bytes[3] = API_AT_CMD;
				rec_d.bytes[4] = id_next;
				rec_d.bytes[5] = at_char0;
				rec_d.bytes[6] = at_char1;
				rec_d.bytes[7] = csum_begin;
				rec_d.has_end  = (count_sat == 7'd0);
				rec_d.cnt      = (count_sat == 7'd0) ? 4'd8 : 4'd7;
				ctr_d          = id_next;
				csum_d         = csum_begin;
				left_d         = count_sat;
			end
			CMD_OPTION: begin
				// An option outside a frame gives no bytes and leaves the state alone.
				if (options_left_q != 7'd0) begin
					rec_d.bytes[0] = option_byte;
					rec_d.bytes[1] = csum_opt;
					rec_d.has_end  = (options_left_q == 7'd1);
					rec_d.cnt      = (options_left_q == 7'd1) ? 4'd2 : 4'd1;
					csum_d         = csum_opt;
					left_d         = options_left_q - 7'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q <= FRAME_ID_RST;
			checksum_q      <= CSUM_INIT;
			options_left_q  <= '0;
			rec_valid_s1    <= 1'b0;
		end else begin
			if (in_acc) begin
				frame_counter_q <= ctr_d;
				checksum_q      <= csum_d;
				options_left_q  <= left_d;
			end
			if (in_acc && rec_d.cnt != 4'd0) begin
				rec_valid_s1 <= 1'b1;
			end else if (rec_take) begin
				rec_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rec_s1 <= rec_d;
		end
	end

	assign rec_valid = rec_valid_s1;
	assign rec       = rec_s1;

endmodule

// File: design/afb_serial.sv
module afb_serial import afb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rec_valid,
	input  afb_rec_t   rec,
	output logic       rec_take,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       frame_end
);

	afb_rec_t   rec_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       last;
	logic       load_ok;

	assign last     = (idx_q == 3'(rec_q.cnt - 4'd1));
	assign load_ok  = !busy_q || (out_ready && last);
	assign rec_take = rec_valid && load_ok;

	assign out_valid  = busy_q;
	assign frame_byte = rec_q.bytes[idx_q];
	assign frame_end  = last && rec_q.has_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (rec_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			rec_q <= rec;
		end
	end

endmodule

// File: design/at_command_frame_builder_top.sv
// AT-command API frame builder. Each input request is either a begin (command 0),
// carrying two AT command characters and an option count, or one option byte
// (command 1). A begin emits 0x7E, 0x00, the length (4 plus the option count,
// saturated at MAX_OPTIONS), 0x08, the frame id and both characters, followed
// by the checksum when there are no options. Each option emits its byte, and
// the last option also emits the checksum, flagged by frame_end. The checksum
// is 0xFF minus the byte sum of 0x08, the frame id, the characters and the
// options. The frame id starts at 0xA1, is incremented before each frame and
// skips zero. Option requests outside a frame are dropped silently, and a
// begin in the middle of a frame abandons that frame. One request is taken per
// cycle while in_ready is high, and the output delivers one byte per cycle
// while out_ready is high; a begin yields seven or eight bytes and an option one
// or two. A request is accepted while the previous one is still being shifted
// out, because a holding register sits between the encoder and byte serializer.
module at_command_frame_builder_top import afb_pkg::*; #(
	parameter int MAX_OPTIONS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] at_char0,
	input  logic [7:0] at_char1,
	input  logic [6:0] option_count,
	input  logic [7:0] option_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       frame_end
);

	logic     rec_valid;
	afb_rec_t rec;
	logic     rec_take;

	// The encoder updates frame id, checksum and option count and registers
	// every byte the request causes.
	afb_encode #(
		.MAX_OPTIONS (MAX_OPTIONS)
	) u_encode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.at_char0     (at_char0),
		.at_char1     (at_char1),
		.option_count (option_count),
		.option_byte  (option_byte),
		.rec_valid    (rec_valid),
		.rec          (rec),
		.rec_take     (rec_take)
	);

	// The serializer hands those bytes out one per cycle while out_ready is high
	// and reloads on the cycle its last byte is taken.
	afb_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (rec_valid),
		.rec        (rec),
		.rec_take   (rec_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

endmodule
